@@ sv/wps_pkg.sv @@
// ---------------------------------------------------------------------------
// Waypoint position stepper package
// Shared types and constants for the controller, datapath and top level.
// ---------------------------------------------------------------------------
package wps_pkg;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int SQRT_STEPS = 33;
   localparam int DIV_STEPS  = 64;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_START = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_NODE_COUNT = 2'd0,
      REG_THRESHOLD  = 2'd1,
      REG_SPEED      = 2'd2,
      REG_MOVING     = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_START,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_THR,
      ST_CMP,
      ST_SQRT,
      ST_MULX,
      ST_MULY,
      ST_DIVLD,
      ST_DIV,
      ST_MOVE,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_WRITE,
      OP_START,
      OP_DIFF,
      OP_SQX,
      OP_SQY,
      OP_THR,
      OP_ARRIVE,
      OP_SQRT_LOAD,
      OP_SQRT_STEP,
      OP_MULX,
      OP_MULY,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_MOVE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         moving;
      logic         reached;
      logic         last;
      logic         root_zero;
      logic         out_free;
   } dp_status_type;

endpackage

@@ sv/wps_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module wps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/wps_ctrl.sv @@
// ---------------------------------------------------------------------------
// Waypoint position stepper controller
// Sequences load, start and tick transactions through the datapath.
// ---------------------------------------------------------------------------
module wps_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  wps_pkg::dp_status_type sts,
   output wps_pkg::dp_cmd_type    cmd
);

   wps_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = wps_pkg::OP_NONE;
      cmd.emit   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         wps_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = wps_pkg::OP_CAPTURE;
               state_in = wps_pkg::ST_DECODE;
            end
         end
         wps_pkg::ST_DECODE: begin
            priority if (sts.kind == wps_pkg::REQ_LOAD) begin
               state_in = wps_pkg::ST_LOAD;
            end else if (sts.kind == wps_pkg::REQ_START) begin
               state_in = wps_pkg::ST_START;
            end else if (sts.kind == wps_pkg::REQ_TICK && sts.moving) begin
               state_in = wps_pkg::ST_DIFF;
            end else begin
               state_in = wps_pkg::ST_EMIT;
            end
         end
         wps_pkg::ST_LOAD: begin
            cmd.op   = wps_pkg::OP_WRITE;
            state_in = wps_pkg::ST_EMIT;
         end
         wps_pkg::ST_START: begin
            cmd.op   = wps_pkg::OP_START;
            state_in = wps_pkg::ST_EMIT;
         end
         wps_pkg::ST_DIFF: begin
            cmd.op   = wps_pkg::OP_DIFF;
            state_in = wps_pkg::ST_SQX;
         end
         wps_pkg::ST_SQX: begin
            cmd.op   = wps_pkg::OP_SQX;
            state_in = wps_pkg::ST_SQY;
         end
         wps_pkg::ST_SQY: begin
            cmd.op   = wps_pkg::OP_SQY;
            state_in = wps_pkg::ST_THR;
         end
         wps_pkg::ST_THR: begin
            cmd.op   = wps_pkg::OP_THR;
            state_in = wps_pkg::ST_CMP;
         end
         wps_pkg::ST_CMP: begin
            if (sts.reached) begin
               cmd.op   = wps_pkg::OP_ARRIVE;
               state_in = wps_pkg::ST_EMIT;
            end else begin
               cmd.op   = wps_pkg::OP_SQRT_LOAD;
               state_in = wps_pkg::ST_SQRT;
            end
         end
         wps_pkg::ST_SQRT: begin
            cmd.op = wps_pkg::OP_SQRT_STEP;
            if (sts.last) begin
               state_in = wps_pkg::ST_MULX;
            end
         end
         wps_pkg::ST_MULX: begin
            if (sts.root_zero) begin
               state_in = wps_pkg::ST_EMIT;
            end else begin
               cmd.op   = wps_pkg::OP_MULX;
               state_in = wps_pkg::ST_MULY;
            end
         end
         wps_pkg::ST_MULY: begin
            cmd.op   = wps_pkg::OP_MULY;
            state_in = wps_pkg::ST_DIVLD;
         end
         wps_pkg::ST_DIVLD: begin
            cmd.op   = wps_pkg::OP_DIV_LOAD;
            state_in = wps_pkg::ST_DIV;
         end
         wps_pkg::ST_DIV: begin
            cmd.op = wps_pkg::OP_DIV_STEP;
            if (sts.last) begin
               state_in = wps_pkg::ST_MOVE;
            end
         end
         wps_pkg::ST_MOVE: begin
            cmd.op   = wps_pkg::OP_MOVE;
            state_in = wps_pkg::ST_EMIT;
         end
         wps_pkg::ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = wps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wps_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result emitted while output register is occupied");
   a_capture_next: assert property (@(posedge clock) disable iff (reset)
      cmd.op == wps_pkg::OP_CAPTURE |=> state_ff == wps_pkg::ST_DECODE)
      else $error("captured transaction was not decoded");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == wps_pkg::ST_IDLE)
      else $error("request accepted outside the idle state");
`endif

endmodule

@@ sv/wps_dp.sv @@
// ---------------------------------------------------------------------------
// Waypoint position stepper datapath
// Waypoint tables, position state, shared multiplier, square root and
// dividers, and the result register.
// ---------------------------------------------------------------------------
module wps_dp #(
   parameter int NODE_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wps_pkg::dp_cmd_type                 cmd,
   output wps_pkg::dp_status_type              sts,
   input  logic [wps_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic [6:0]                          node_count,
   input  logic [30:0]                         arrive_threshold,
   input  logic [30:0]                         speed,
   input  logic                                moving,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wps_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser
);

   localparam int IDX_W  = NODE_MAX > 1 ? $clog2(NODE_MAX) : 1;
   localparam int NMAX_C = NODE_MAX > 127 ? 127 : NODE_MAX;
   localparam int PW     = IDX_W > 7 ? IDX_W : 7;
   localparam int DW     = IDX_W > 6 ? IDX_W : 6;

   logic [1:0]  kind_ff;
   logic [5:0]  nidx_ff;
   logic [31:0] nx_ff, ny_ff;
   logic [15:0] pf_ff, ps_ff;

   logic [31:0]      posx_ff, posx_in, posy_ff, posy_in;
   logic [IDX_W-1:0] dest_ff, dest_in;
   logic             arr_ff, arr_in;
   logic [32:0]      dx_ff, dy_ff;
   logic [65:0]      prod_ff, acc_ff, acc_in;
   logic [35:0]      sqrem_ff, sqrem_in;
   logic [32:0]      root_ff, root_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic [63:0]      numx_ff, numx_in, numy_ff, numy_in;
   logic [33:0]      remx_ff, remx_in, remy_ff, remy_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [69:0]      rsp_data_ff;
   logic             rsp_arr_ff;

   logic [31:0]      ramx, ramy;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr, pick_f, pick_s;
   logic [6:0]       ncl;
   logic [22:0]      prod_f, prod_s;
   logic [PW-1:0]    wide_f, wide_s;
   logic [DW-1:0]    wide_wr, wide_dest;
   logic [32:0]      magx, magy, mul_a, mul_b;
   logic [65:0]      mul_p;
   logic [35:0]      rem_sh, trial;
   logic             sq_ge;
   logic [33:0]      remx_sh, remy_sh, divisor, qcx, qcy;
   logic             gex, gey;
   logic [35:0]      stepx, stepy, sumx, sumy;
   logic [31:0]      satx, saty;

   // Node selection: index = fraction * count >> 16.
   always_comb begin
      if (node_count == 7'd0) begin
         ncl = 7'd1;
      end else if (node_count > 7'(NMAX_C)) begin
         ncl = 7'(NMAX_C);
      end else begin
         ncl = node_count;
      end
      prod_f = pf_ff * ncl;
      prod_s = ps_ff * ncl;
      wide_f = PW'(prod_f[22:16]);
      wide_s = PW'(prod_s[22:16]);
      pick_f = wide_f[IDX_W-1:0];
      pick_s = wide_s[IDX_W-1:0];
   end

   assign wide_wr = DW'(nidx_ff);
   assign wr_addr = wide_wr[IDX_W-1:0];
   assign wr_en   = (cmd.op == wps_pkg::OP_WRITE) && (32'(nidx_ff) < NODE_MAX);
   assign rd_addr = (kind_ff == wps_pkg::REQ_START) ? pick_f : dest_ff;

   wps_ram #(.WIDTH(32), .DEPTH(NODE_MAX)) u_ram_x (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (nx_ff),
      .rd_addr (rd_addr),
      .rd_data (ramx)
   );

   wps_ram #(.WIDTH(32), .DEPTH(NODE_MAX)) u_ram_y (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ny_ff),
      .rd_addr (rd_addr),
      .rd_data (ramy)
   );

   assign magx = dx_ff[32] ? 33'(-dx_ff) : dx_ff;
   assign magy = dy_ff[32] ? 33'(-dy_ff) : dy_ff;

   always_comb begin
      unique case (cmd.op)
         wps_pkg::OP_SQX: begin
            mul_a = magx;
            mul_b = magx;
         end
         wps_pkg::OP_SQY: begin
            mul_a = magy;
            mul_b = magy;
         end
         wps_pkg::OP_THR: begin
            mul_a = 33'(arrive_threshold);
            mul_b = 33'(arrive_threshold);
         end
         wps_pkg::OP_MULX: begin
            mul_a = 33'(speed);
            mul_b = magx;
         end
         default: begin
            mul_a = 33'(speed);
            mul_b = magy;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Square root, one result bit per step.
   assign rem_sh = {sqrem_ff[33:0], acc_ff[65:64]};
   assign trial  = 36'({root_ff, 2'b01});
   assign sq_ge  = rem_sh >= trial;

   // Two division lanes sharing the root as divisor.
   assign divisor = {1'b0, root_ff};
   assign remx_sh = {remx_ff[32:0], numx_ff[63]};
   assign remy_sh = {remy_ff[32:0], numy_ff[63]};
   assign gex     = remx_sh >= divisor;
   assign gey     = remy_sh >= divisor;

   assign qcx = (numx_ff > 64'h2_0000_0000) ? 34'h2_0000_0000 : numx_ff[33:0];
   assign qcy = (numy_ff > 64'h2_0000_0000) ? 34'h2_0000_0000 : numy_ff[33:0];

   always_comb begin
      stepx = dx_ff[32] ? 36'(-{2'b00, qcx}) : {2'b00, qcx};
      stepy = dy_ff[32] ? 36'(-{2'b00, qcy}) : {2'b00, qcy};
      sumx  = {{4{posx_ff[31]}}, posx_ff} + stepx;
      sumy  = {{4{posy_ff[31]}}, posy_ff} + stepy;
      if (!sumx[35] && sumx[34:31] != 4'd0) begin
         satx = 32'h7FFF_FFFF;
      end else if (sumx[35] && sumx[34:31] != 4'hF) begin
         satx = 32'h8000_0000;
      end else begin
         satx = sumx[31:0];
      end
      if (!sumy[35] && sumy[34:31] != 4'd0) begin
         saty = 32'h7FFF_FFFF;
      end else if (sumy[35] && sumy[34:31] != 4'hF) begin
         saty = 32'h8000_0000;
      end else begin
         saty = sumy[31:0];
      end
   end

   always_comb begin
      posx_in  = posx_ff;
      posy_in  = posy_ff;
      dest_in  = dest_ff;
      arr_in   = arr_ff;
      acc_in   = acc_ff;
      sqrem_in = sqrem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      numx_in  = numx_ff;
      numy_in  = numy_ff;
      remx_in  = remx_ff;
      remy_in  = remy_ff;
      unique case (cmd.op)
         wps_pkg::OP_CAPTURE: begin
            arr_in = 1'b0;
         end
         wps_pkg::OP_START: begin
            posx_in = ramx;
            posy_in = ramy;
            dest_in = pick_s;
         end
         wps_pkg::OP_SQY: begin
            acc_in = prod_ff;
         end
         wps_pkg::OP_THR: begin
            acc_in = acc_ff + prod_ff;
         end
         wps_pkg::OP_ARRIVE: begin
            dest_in = pick_f;
            arr_in  = 1'b1;
         end
         wps_pkg::OP_SQRT_LOAD: begin
            sqrem_in = 36'd0;
            root_in  = 33'd0;
            cnt_in   = 7'(wps_pkg::SQRT_STEPS);
         end
         wps_pkg::OP_SQRT_STEP: begin
            acc_in   = {acc_ff[63:0], 2'b00};
            sqrem_in = sq_ge ? rem_sh - trial : rem_sh;
            root_in  = {root_ff[31:0], sq_ge};
            cnt_in   = cnt_ff - 7'd1;
         end
         wps_pkg::OP_MULY: begin
            numx_in = prod_ff[63:0];
         end
         wps_pkg::OP_DIV_LOAD: begin
            numy_in = prod_ff[63:0];
            remx_in = 34'd0;
            remy_in = 34'd0;
            cnt_in  = 7'(wps_pkg::DIV_STEPS);
         end
         wps_pkg::OP_DIV_STEP: begin
            remx_in = gex ? remx_sh - divisor : remx_sh;
            remy_in = gey ? remy_sh - divisor : remy_sh;
            numx_in = {numx_ff[62:0], gex};
            numy_in = {numy_ff[62:0], gey};
            cnt_in  = cnt_ff - 7'd1;
         end
         wps_pkg::OP_MOVE: begin
            posx_in = satx;
            posy_in = saty;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         posx_ff <= 32'd0;
         posy_ff <= 32'd0;
         dest_ff <= '0;
         cnt_ff  <= 7'd0;
      end else begin
         posx_ff <= posx_in;
         posy_ff <= posy_in;
         dest_ff <= dest_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == wps_pkg::OP_CAPTURE) begin
         kind_ff <= req_tuser;
         nidx_ff <= req_tdata[5:0];
         nx_ff   <= req_tdata[37:6];
         ny_ff   <= req_tdata[69:38];
         pf_ff   <= req_tdata[85:70];
         ps_ff   <= req_tdata[101:86];
      end
      if (cmd.op == wps_pkg::OP_DIFF) begin
         dx_ff <= {ramx[31], ramx} - {posx_ff[31], posx_ff};
         dy_ff <= {ramy[31], ramy} - {posy_ff[31], posy_ff};
      end
      prod_ff  <= mul_p;
      arr_ff   <= arr_in;
      acc_ff   <= acc_in;
      sqrem_ff <= sqrem_in;
      root_ff  <= root_in;
      numx_ff  <= numx_in;
      numy_ff  <= numy_in;
      remx_ff  <= remx_in;
      remy_ff  <= remy_in;
   end

   // Result register.
   assign wide_dest = DW'(dest_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {wide_dest[5:0], posy_ff, posx_ff};
         rsp_arr_ff  <= arr_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tuser  = rsp_arr_ff;

   assign sts.kind      = wps_pkg::req_kind_type'(kind_ff);
   assign sts.moving    = moving;
   assign sts.reached   = acc_ff <= prod_ff;
   assign sts.last      = cnt_ff == 7'd1;
   assign sts.root_zero = root_ff == 33'd0;
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

`ifndef SYNTHESIS
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.op == wps_pkg::OP_DIV_STEP |-> remx_ff < divisor && remy_ff < divisor)
      else $error("division remainder not below divisor");
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.op == wps_pkg::OP_SQRT_STEP |-> sqrem_ff <= 36'({root_ff, 1'b0}))
      else $error("square root remainder out of range");
   a_arrive_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.op == wps_pkg::OP_ARRIVE |=> $stable(posx_ff) && $stable(posy_ff))
      else $error("position changed on arrival");
`endif

endmodule

@@ sv/waypoint_position_stepper_unit.sv @@
// ---------------------------------------------------------------------------
// Waypoint position stepper unit
// Simulated position source that travels between loaded waypoints.
// ---------------------------------------------------------------------------
// Each transaction on the req_ stream produces exactly one rsp_ transaction
// with the position and destination after it. req_tuser selects a load, a
// start or a tick; loads fill the waypoint tables, a start places the
// position on a chosen waypoint, and a tick measures the distance to the
// destination and either picks a new destination or steps toward it.
// The block handles one transaction at a time. A load or start writes the
// table or the position and loads the result. A tick that reaches its
// destination picks a new one; a moving tick also runs the bit-serial square
// root, then the two radix-2 dividers that work side by side. Inactive ticks
// and requests of type three go straight to the result. The next transaction
// is accepted in the cycle after the result is loaded. The result waits in an
// output register while rsp_tready is low; the controller stalls only when a
// second result is ready before the first one leaves. Reset clears position
// and destination and resets the registers; the waypoint tables hold their
// contents and must be loaded before use. Registers must be written over the
// csr_ port only while the block is idle; the user, not the block, ensures it.
// ---------------------------------------------------------------------------
module waypoint_position_stepper_unit #(
   parameter int NODE_MAX = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // node_index, node_x, node_y, pick_first, pick_second
   input  logic [wps_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_type
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pos_x, pos_y, dest_index
   output logic [wps_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // arrived
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wps_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wps_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wps_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   logic [6:0]  node_count_ff;
   logic [30:0] threshold_ff;
   logic [30:0] speed_ff;
   logic        moving_ff;
   logic        csr_write;
   wps_pkg::csr_reg_type csr_index;

   wps_pkg::dp_cmd_type    cmd;
   wps_pkg::dp_status_type sts;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = wps_pkg::csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 7'd1;
         threshold_ff  <= 31'd0;
         speed_ff      <= 31'd0;
         moving_ff     <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            wps_pkg::REG_NODE_COUNT: node_count_ff <= csr_pwdata[6:0];
            wps_pkg::REG_THRESHOLD:  threshold_ff  <= csr_pwdata[30:0];
            wps_pkg::REG_SPEED:      speed_ff      <= csr_pwdata[30:0];
            wps_pkg::REG_MOVING:     moving_ff     <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         wps_pkg::REG_NODE_COUNT: csr_prdata = 32'(node_count_ff);
         wps_pkg::REG_THRESHOLD:  csr_prdata = 32'(threshold_ff);
         wps_pkg::REG_SPEED:      csr_prdata = 32'(speed_ff);
         wps_pkg::REG_MOVING:     csr_prdata = 32'(moving_ff);
         default:                 csr_prdata = 32'd0;
      endcase
   end

   wps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   wps_dp #(.NODE_MAX(NODE_MAX)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .node_count       (node_count_ff),
      .arrive_threshold (threshold_ff),
      .speed            (speed_ff),
      .moving           (moving_ff),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser)
   );

endmodule

@@ bench/wps_checker.sv @@
// ---------------------------------------------------------------------------
// Waypoint position stepper checker
// Watches the request, result and register channels, keeps its own model of
// the waypoint tables, position and registers, and compares every result
// transaction field by field with the oldest predicted one.
// ---------------------------------------------------------------------------
module wps_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [wps_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [wps_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [wps_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wps_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             fail_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        arrived;
      logic [5:0]  dest;
      logic [31:0] pos_y;
      logic [31:0] pos_x;
   } fix_type;

   logic signed [63:0] wp_x [64];
   logic signed [63:0] wp_y [64];
   logic signed [63:0] here_x, here_y;
   logic [5:0]         dest_node;
   logic [6:0]         node_count;
   logic [30:0]        threshold, speed;
   logic               moving;
   fix_type            expected_fixes[$];

   task automatic report(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic logic [5:0] choose_node(input logic [15:0] frac);
      logic [6:0] n;
      n = node_count == 7'd0 ? 7'd1 : (node_count > 7'd64 ? 7'd64 : node_count);
      return 6'((32'(frac) * 32'(n)) >> 16);
   endfunction

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [63:0] axis_advance(input logic signed [63:0] d,
                                                      input logic [63:0] span);
      logic [63:0] s, m;
      m = d < 0 ? 64'(-d) : 64'(d);
      s = (64'(speed) * m) / span;
      if (s > 64'h2_0000_0000) s = 64'h2_0000_0000;
      return d < 0 ? -$signed(s) : $signed(s);
   endfunction

   task automatic advance_state(input logic [1:0] kind, input logic [103:0] d);
      logic signed [63:0]  dx, dy;
      logic signed [127:0] wx, wy;
      logic [127:0]        sq, lim, c;
      logic [63:0]         root;
      fix_type             f;
      f.arrived = 1'b0;
      if (kind == wps_pkg::REQ_LOAD) begin
         wp_x[d[5:0]] = 64'($signed(d[37:6]));
         wp_y[d[5:0]] = 64'($signed(d[69:38]));
      end else if (kind == wps_pkg::REQ_START) begin
         here_x = wp_x[choose_node(d[85:70])];
         here_y = wp_y[choose_node(d[85:70])];
         dest_node = choose_node(d[101:86]);
      end else if (kind == wps_pkg::REQ_TICK && moving) begin
         dx = wp_x[dest_node] - here_x;
         dy = wp_y[dest_node] - here_y;
         wx = dx;
         wy = dy;
         sq = wx * wx + wy * wy;
         lim = 128'(threshold) * 128'(threshold);
         if (sq <= lim) begin
            dest_node = choose_node(d[85:70]);
            f.arrived = 1'b1;
         end else begin
            root = '0;
            for (int b = 32; b >= 0; b--) begin
               c = 128'(root | (64'd1 << b));
               if (c * c <= sq) root = 64'(c);
            end
            if (root != 0) begin
               here_x = clamp32(here_x + axis_advance(dx, root));
               here_y = clamp32(here_y + axis_advance(dy, root));
            end
         end
      end
      f.pos_x = here_x[31:0];
      f.pos_y = here_y[31:0];
      f.dest = dest_node;
      expected_fixes.push_back(f);
   endtask

   always @(posedge clock) begin
      fix_type want;
      fix_type got;
      if (reset) begin
         here_x <= '0;
         here_y <= '0;
         dest_node <= '0;
         node_count <= 7'd1;
         threshold <= '0;
         speed <= '0;
         moving <= 1'b0;
         fail_count <= 0;
         pending_count <= 0;
         expected_fixes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (wps_pkg::csr_reg_type'(csr_paddr[3:2]))
               wps_pkg::REG_NODE_COUNT: node_count = csr_pwdata[6:0];
               wps_pkg::REG_THRESHOLD: threshold = csr_pwdata[30:0];
               wps_pkg::REG_SPEED: speed = csr_pwdata[30:0];
               wps_pkg::REG_MOVING: moving = csr_pwdata[0];
            endcase
         end
         if (req_tvalid && req_tready) advance_state(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[69:0]};
            if (expected_fixes.size() == 0) begin
               report("unexpected transaction", 64'(rsp_tdata), 64'd0);
            end else begin
               want = expected_fixes.pop_front();
               if (got.pos_x !== want.pos_x)
                  report("pos_x", 64'(got.pos_x), 64'(want.pos_x));
               if (got.pos_y !== want.pos_y)
                  report("pos_y", 64'(got.pos_y), 64'(want.pos_y));
               if (got.dest !== want.dest)
                  report("dest_index", 64'(got.dest), 64'(want.dest));
               if (got.arrived !== want.arrived)
                  report("arrived", 64'(got.arrived), 64'(want.arrived));
            end
         end
         pending_count <= expected_fixes.size();
      end
   end
endmodule

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// Waypoint position stepper testbench
// Loads waypoints, starts and ticks the stepper through several register
// settings with random gaps and stalls, and leaves checking to the checker.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic                           clock, reset;
   logic                           req_tvalid, req_tready, rsp_tvalid, rsp_tready, rsp_tuser;
   logic [wps_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                     req_tuser;
   logic [wps_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [wps_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [wps_pkg::CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   int                             fail_count, pending_count, cycle_count;
   bit                             hold_off;
   logic [6:0]                     loaded;

   waypoint_position_stepper_unit dut (.*);
   wps_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 3_000_000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      return $urandom_range(0, 9) == 0 ? $urandom_range(5, 40) :
             ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
   endfunction

   initial begin
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 0;
         end else if ($urandom_range(0, 40) == 0) begin
            rsp_tready <= 1'b0;
            repeat (1 + gap_len()) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0) || cycle_count % 2000 < 500;
            @(negedge clock);
         end
      end
   end

   task automatic csr_write(input wps_pkg::csr_reg_type r, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= wps_pkg::CSR_ADDR_W'(r) << 2;
      csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send(input wps_pkg::req_kind_type k, input logic [5:0] idx,
                       input logic [31:0] x, input logic [31:0] y,
                       input logic [15:0] p1, input logic [15:0] p2);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= k;
      req_tdata <= {2'b0, p2, p1, y, x, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      gap = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   function automatic logic [31:0] coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 4000)) - 2000) << 20;
         2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 200)) - 100);
      endcase
   endfunction

   function automatic logic [15:0] pick();
      return $urandom_range(0, 3) == 0 ? ($urandom_range(0, 1) ? 16'hffff : 16'h0) :
             16'($urandom);
   endfunction

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tuser = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      hold_off = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // Directed part: fill every slot, then extremes and each request kind.
      for (int i = 0; i < 64; i++) begin
         send(wps_pkg::REQ_LOAD, 6'(i), coord(), coord(), 16'h0, 16'h0);
      end
      send(wps_pkg::REQ_LOAD, 6'd0, 32'h7fff_ffff, 32'h8000_0000, 16'hffff, 16'hffff);
      send(wps_pkg::REQ_LOAD, 6'd63, 32'h8000_0000, 32'h7fff_ffff, 16'h0, 16'h0);
      send(wps_pkg::REQ_TICK, 6'd0, 32'd0, 32'd0, 16'hffff, 16'h0);
      send(wps_pkg::REQ_NONE, 6'h3f, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
      send(wps_pkg::REQ_START, 6'd0, 32'd0, 32'd0, 16'h0, 16'hffff);
      settle();
      csr_write(wps_pkg::REG_NODE_COUNT, 32'd64);
      csr_write(wps_pkg::REG_THRESHOLD, 32'd0);
      csr_write(wps_pkg::REG_SPEED, 32'h7fff_ffff);
      csr_write(wps_pkg::REG_MOVING, 32'd1);
      send(wps_pkg::REQ_START, 6'd0, 32'd0, 32'd0, 16'h0, 16'hffff);
      send(wps_pkg::REQ_TICK, 6'd0, 32'd0, 32'd0, 16'h1234, 16'h0);
      send(wps_pkg::REQ_TICK, 6'd0, 32'd0, 32'd0, 16'hffff, 16'h0);
      send(wps_pkg::REQ_START, 6'd0, 32'd0, 32'd0, 16'h8000, 16'h8000);
      send(wps_pkg::REQ_TICK, 6'd0, 32'd0, 32'd0, 16'h0, 16'h0);
      send(wps_pkg::REQ_NONE, 6'd0, 32'd0, 32'd0, 16'h0, 16'h0);
      settle();
      // Random phases over a range of register settings.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: loaded = 7'd0;
            1: loaded = 7'd127;
            2: loaded = 7'd1;
            default: loaded = 7'($urandom_range(0, 127));
         endcase
         csr_write(wps_pkg::REG_NODE_COUNT, 32'(loaded));
         csr_write(wps_pkg::REG_THRESHOLD, phase == 1 ? 32'h7fff_ffff :
                   (phase == 2 ? 32'd0 : $urandom_range(0, 1 << 24)));
         csr_write(wps_pkg::REG_SPEED, phase == 3 ? 32'd0 : (phase == 4 ? 32'h7fff_ffff :
                   $urandom_range(1 << 18, 1 << 24)));
         csr_write(wps_pkg::REG_MOVING, 32'(phase != 5));
         if (phase == 6) hold_off = 1;
         for (int n = 0; n < 250; n++) begin
            case ($urandom_range(0, 19))
               0, 1: send(wps_pkg::REQ_LOAD, 6'($urandom), coord(), coord(), pick(), pick());
               2: send(wps_pkg::REQ_START, 6'($urandom), $urandom, $urandom, pick(), pick());
               3: send(wps_pkg::REQ_NONE, 6'($urandom), $urandom, $urandom, pick(), pick());
               default: send(wps_pkg::REQ_TICK, 6'($urandom), $urandom, $urandom,
                             pick(), pick());
            endcase
         end
         settle();
      end
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

@@ files.f @@
sv/wps_pkg.sv
sv/wps_ram.sv
sv/wps_ctrl.sv
sv/wps_dp.sv
sv/waypoint_position_stepper_unit.sv
bench/wps_checker.sv
bench/testbench.sv
